// File: rtl/core/assert_macros.svh
// Assertion helpers for the core. Every check runs on clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition is never true.
`define ASSERT_NEVER(lbl, cond) \
	`ASSERT_CLK(lbl, !(cond))

`endif

// File: rtl/core/ascp_pkg.sv
`timescale 1ns / 1ps

package ascp_pkg;

	localparam int NUM_RC = 12;
	localparam int RND_W = $clog2(NUM_RC + 1);

	typedef logic [63:0] word_t;
	typedef logic [4:0][63:0] state_t;
	typedef logic [RND_W-1:0] rnd_t;

	typedef enum logic [1:0] {
		OP_P12  = 2'd0,
		OP_P8   = 2'd1,
		OP_P6   = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef struct packed {
		logic load;
		logic round_en;
		logic emit;
		rnd_t rnd_idx;
	} dp_cmd_t;

	function automatic logic [7:0] ascp_rc(input rnd_t idx);
		logic [7:0] rc;
		case (idx)
			RND_W'(0):  rc = 8'hf0;
			RND_W'(1):  rc = 8'he1;
			RND_W'(2):  rc = 8'hd2;
			RND_W'(3):  rc = 8'hc3;
			RND_W'(4):  rc = 8'hb4;
			RND_W'(5):  rc = 8'ha5;
			RND_W'(6):  rc = 8'h96;
			RND_W'(7):  rc = 8'h87;
			RND_W'(8):  rc = 8'h78;
			RND_W'(9):  rc = 8'h69;
			RND_W'(10): rc = 8'h5a;
			RND_W'(11): rc = 8'h4b;
			default:    rc = 8'h00;
		endcase
		return rc;
	endfunction

	// Index of the first round constant; NUM_RC means no rounds at all.
	function automatic rnd_t ascp_first_round(input opcode_t op);
		rnd_t r;
		case (op)
			OP_P12:  r = RND_W'(0);
			OP_P8:   r = RND_W'(4);
			OP_P6:   r = RND_W'(6);
			default: r = RND_W'(NUM_RC);
		endcase
		return r;
	endfunction

	function automatic word_t ror64(input word_t v, input logic [5:0] r);
		return (v >> r) | (v << (7'd64 - {1'b0, r}));
	endfunction

	function automatic state_t ascp_round(input state_t s, input logic [7:0] rc);
		word_t a0, a1, a2, a3, a4;
		word_t t0, t1, t2, t3, t4;
		state_t o;
		a0 = s[0];
		a1 = s[1];
		a2 = s[2] ^ {56'd0, rc};
		a3 = s[3];
		a4 = s[4];
		// s-box layer, bitsliced
		a0 = a0 ^ a4;
		a4 = a4 ^ a3;
		a2 = a2 ^ a1;
		t0 = ~a0 & a1;
		t1 = ~a1 & a2;
		t2 = ~a2 & a3;
		t3 = ~a3 & a4;
		t4 = ~a4 & a0;
		a0 = a0 ^ t1;
		a1 = a1 ^ t2;
		a2 = a2 ^ t3;
		a3 = a3 ^ t4;
		a4 = a4 ^ t0;
		a1 = a1 ^ a0;
		a0 = a0 ^ a4;
		a3 = a3 ^ a2;
		a2 = ~a2;
		// linear diffusion
		o[0] = a0 ^ ror64(a0, 6'd19) ^ ror64(a0, 6'd28);
		o[1] = a1 ^ ror64(a1, 6'd61) ^ ror64(a1, 6'd39);
		o[2] = a2 ^ ror64(a2, 6'd1) ^ ror64(a2, 6'd6);
		o[3] = a3 ^ ror64(a3, 6'd10) ^ ror64(a3, 6'd17);
		o[4] = a4 ^ ror64(a4, 6'd7) ^ ror64(a4, 6'd41);
		return o;
	endfunction

endpackage

// File: rtl/core/ascon_permutation_core.sv
// Ascon permutation core: p12, p8 or p6 on a 320-bit state of five 64-bit words.
// Input channel: in_valid/in_ready carries opcode and in_word0..in_word4.
//   opcode 0 runs 12 rounds, 1 runs 8, 2 runs 6; opcode 3 passes the state through.
// Output channel: out_valid/out_ready carries out_word0..out_word4, one beat
//   per input beat, in order.
// One round per clock on a single shared round datapath; a round counter in the
// controller walks the round constants from the opcode's start index to the last one.
// in_ready is high only while the controller is idle, so a new input beat is not taken
//   until the previous one has run its rounds and moved to the output register.
// Results sit in an output register, so the next beat is accepted while the
// previous result still waits. If the receiver stalls, the finished state is held
// in the working register and in_ready stays low until the output register frees.
// Reset clears the controller and drops any pending result; out_valid is low and
// in_ready high right after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascon_permutation_core
	import ascp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [63:0] in_word0,
	input  logic [63:0] in_word1,
	input  logic [63:0] in_word2,
	input  logic [63:0] in_word3,
	input  logic [63:0] in_word4,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_word0,
	output logic [63:0] out_word1,
	output logic [63:0] out_word2,
	output logic [63:0] out_word3,
	output logic [63:0] out_word4
);

	dp_cmd_t cmd;

	ascp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ascp_datapath u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.in_word0  (in_word0),
		.in_word1  (in_word1),
		.in_word2  (in_word2),
		.in_word3  (in_word3),
		.in_word4  (in_word4),
		.out_word0 (out_word0),
		.out_word1 (out_word1),
		.out_word2 (out_word2),
		.out_word3 (out_word3),
		.out_word4 (out_word4)
	);

	// one item in flight: no second accept right after the first
	`ASSERT_CLK(a_one_in_flight, (in_valid && in_ready) |=> !in_ready)
	// a finished state never overwrites a result the receiver has not taken
	`ASSERT_CLK(a_no_overwrite, cmd.emit |-> (!out_valid || out_ready))
	// rounds only run with a valid constant index
	`ASSERT_CLK(a_rnd_range, cmd.round_en |-> (cmd.rnd_idx < RND_W'(NUM_RC)))
	// load, round and emit never coincide
	`ASSERT_NEVER(a_cmd_excl, (cmd.load && (cmd.round_en || cmd.emit)) || (cmd.round_en && cmd.emit))

endmodule

// File: rtl/core/ascp_datapath.sv
`timescale 1ns / 1ps

module ascp_datapath
	import ascp_pkg::*;
(
	input  logic    clk,
	input  dp_cmd_t cmd,
	input  word_t   in_word0,
	input  word_t   in_word1,
	input  word_t   in_word2,
	input  word_t   in_word3,
	input  word_t   in_word4,
	output word_t   out_word0,
	output word_t   out_word1,
	output word_t   out_word2,
	output word_t   out_word3,
	output word_t   out_word4
);

	state_t st_q;
	state_t out_q;
	state_t st_next;

	assign st_next = ascp_round(st_q, ascp_rc(cmd.rnd_idx));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q <= {in_word4, in_word3, in_word2, in_word1, in_word0};
		end else if (cmd.round_en) begin
			st_q <= st_next;
		end
		if (cmd.emit) begin
			out_q <= st_q;
		end
	end

	assign out_word0 = out_q[0];
	assign out_word1 = out_q[1];
	assign out_word2 = out_q[2];
	assign out_word3 = out_q[3];
	assign out_word4 = out_q[4];

endmodule

// File: rtl/core/ascp_ctrl.sv
`timescale 1ns / 1ps

module ascp_ctrl
	import ascp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} ctrl_state_t;

	ctrl_state_t state_q;
	rnd_t        rnd_q;
	logic        out_valid_q;
	logic        accept;
	logic        slot_free;
	rnd_t        first;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign first     = ascp_first_round(opcode_t'(opcode));
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load     = accept;
		cmd.round_en = (state_q == ST_RUN);
		cmd.emit     = (state_q == ST_HOLD) && slot_free;
		cmd.rnd_idx  = rnd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rnd_q   <= first;
						state_q <= (first == RND_W'(NUM_RC)) ? ST_HOLD : ST_RUN;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_W'(NUM_RC - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// wait until the output register is free
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ascp_pkg::*;

	localparam int RANDOM_BEATS = 1250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = OP_P12;
	logic [63:0] in_word0 = '0;
	logic [63:0] in_word1 = '0;
	logic [63:0] in_word2 = '0;
	logic [63:0] in_word3 = '0;
	logic [63:0] in_word4 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] out_word0;
	logic [63:0] out_word1;
	logic [63:0] out_word2;
	logic [63:0] out_word3;
	logic [63:0] out_word4;

	bit send_burst = 1'b0;
	int unsigned cycle_count = 0;

	ascon_permutation_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.in_word0  (in_word0),
		.in_word1  (in_word1),
		.in_word2  (in_word2),
		.in_word3  (in_word3),
		.in_word4  (in_word4),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word0 (out_word0),
		.out_word1 (out_word1),
		.out_word2 (out_word2),
		.out_word3 (out_word3),
		.out_word4 (out_word4)
	);

	class perm_scoreboard;
		state_t permuted_states[$];
		int mismatches = 0;

		static function word_t rotr(word_t v, int n);
			return (v >> n) | (v << (64 - n));
		endfunction

		static function state_t perm_round(state_t st, logic [7:0] rc);
			word_t x0, x1, x2, x3, x4;
			word_t n0, n1, n2, n3, n4;
			state_t nxt;
			x0 = st[0];
			x1 = st[1];
			x2 = st[2] ^ {56'd0, rc};
			x3 = st[3];
			x4 = st[4];
			x0 ^= x4;
			x4 ^= x3;
			x2 ^= x1;
			n0 = ~x0 & x1;
			n1 = ~x1 & x2;
			n2 = ~x2 & x3;
			n3 = ~x3 & x4;
			n4 = ~x4 & x0;
			x0 ^= n1;
			x1 ^= n2;
			x2 ^= n3;
			x3 ^= n4;
			x4 ^= n0;
			x1 ^= x0;
			x0 ^= x4;
			x3 ^= x2;
			x2 = ~x2;
			nxt[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
			nxt[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
			nxt[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
			nxt[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
			nxt[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
			return nxt;
		endfunction

		static function state_t permute(opcode_t op, state_t st);
			int first;
			case (op)
				OP_P12:  first = 0;
				OP_P8:   first = 4;
				OP_P6:   first = 6;
				default: first = 12;
			endcase
			// constant for round r: high nibble 15 - r, low nibble r
			for (int r = first; r < 12; r++)
				st = perm_round(st, {4'(15 - r), 4'(r)});
			return st;
		endfunction

		function void record_beat(opcode_t op, state_t st);
			permuted_states.push_back(permute(op, st));
		endfunction

		function void check_beat(state_t got);
			state_t want;
			if (permuted_states.size() == 0) begin
				$display("%0t: result with nothing pending: %h", $time, got);
				mismatches++;
				return;
			end
			want = permuted_states.pop_front();
			for (int i = 0; i < 5; i++)
				if (got[i] !== want[i]) begin
					$display("%0t: out_word%0d expected %h actual %h",
						$time, i, want[i], got[i]);
					mismatches++;
				end
		endfunction
	endclass

	perm_scoreboard sb = new;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ascon_permutation_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.record_beat(opcode_t'(opcode),
				{in_word4, in_word3, in_word2, in_word1, in_word0});
		if (arst_n && out_valid && out_ready)
			sb.check_beat({out_word4, out_word3, out_word2, out_word1, out_word0});
	end

	// Result side: random stalls, bursts of steady ready, and two long hold-offs.
	initial begin
		int beats;
		int gap;
		beats = 0;
		@(posedge arst_n);
		forever begin
			gap = ((beats / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
			if (beats == 300 || beats == 900)
				gap = LONG_HOLD;
			repeat (gap) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			beats++;
		end
	end

	task automatic send_beat(input opcode_t op, input state_t st);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		in_word0 <= st[0];
		in_word1 <= st[1];
		in_word2 <= st[2];
		in_word3 <= st[3];
		in_word4 <= st[4];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic word_t random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic state_t random_state();
		state_t st;
		for (int i = 0; i < 5; i++)
			st[i] = random_word();
		return st;
	endfunction

	initial begin
		state_t st;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero and all-one states under every opcode
		for (int op = 0; op < 4; op++) begin
			send_beat(opcode_t'(op), '0);
			send_beat(opcode_t'(op), '1);
		end
		for (int op = 0; op < 3; op++)
			send_beat(opcode_t'(op), {5{64'haaaa_aaaa_5555_5555}});
		for (int i = 0; i < 5; i++)
			st[i] = 64'h1 << (i * 16);
		send_beat(OP_P12, st);
		for (int i = 0; i < 5; i++)
			st[i] = 64'h8000_0000_0000_0000 >> i;
		send_beat(OP_P8, st);
		// first round constant cancels the low byte of word 2
		st = '0;
		st[2] = 64'hf0;
		send_beat(OP_P12, st);
		st[2] = 64'hb4;
		send_beat(OP_P8, st);
		st[2] = 64'h96;
		send_beat(OP_P6, st);
		send_beat(OP_NONE, random_state());
		send_beat(OP_NONE, random_state());

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			send_burst = ((n / 64) % 3 == 1);
			if (n == RANDOM_BEATS / 2) begin
				// drain the block before going on
				in_valid <= 1'b0;
				@(posedge clk);
				while (sb.permuted_states.size() != 0)
					@(posedge clk);
			end
			send_beat(opcode_t'($urandom_range(0, 3)), random_state());
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (sb.permuted_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("ascon_permutation_core regression: pass");
		else
			$display("ascon_permutation_core regression: fail");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ascp_pkg.sv
rtl/core/ascp_datapath.sv
rtl/core/ascp_ctrl.sv
rtl/core/ascon_permutation_core.sv
test/testbench.sv
